[rtl/core/bdd_pkg.sv]
// Shared types, constants and a helper function for the binary to decimal digit converter.
`default_nettype none
package bdd_pkg;

  localparam int unsigned DEFAULT_VALUE_BITS = 64;
  localparam int unsigned INPUT_BITS         = 64;
  localparam int unsigned CHAR_BITS          = 6;
  localparam int unsigned BCD_BITS           = 4;
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

  // Number of decimal digits in the largest value of the given width.
  function automatic int unsigned max_digits(input int unsigned bits);
    max_digits = ((bits * 1233) >> 12) + 1;
  endfunction

  typedef struct packed {
    logic load;
    logic dabble;
    logic dshift;
  } bdd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } bdd_state_t;

endpackage
`default_nettype wire

[rtl/core/bdd_dabble.sv]
// Shift-and-add-3 datapath holding the binary shift register and the BCD digit register.
`default_nettype none
module bdd_dabble
  import bdd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS,
  parameter int unsigned NUM_DIGITS = max_digits(DEFAULT_VALUE_BITS)
) (
  input  wire logic                   clk,
  input  wire bdd_ctl_t               ctl,
  input  wire logic [INPUT_BITS-1:0]  load_value,
  output logic      [BCD_BITS-1:0]    top_digit
);

  localparam int unsigned BCD_W = BCD_BITS * NUM_DIGITS;

  logic [VALUE_BITS-1:0] bin_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      adjusted;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*BCD_BITS +: BCD_BITS] > 4'd4) begin
        adjusted[i*BCD_BITS +: BCD_BITS] = bcd_r[i*BCD_BITS +: BCD_BITS] + 4'd3;
      end else begin
        adjusted[i*BCD_BITS +: BCD_BITS] = bcd_r[i*BCD_BITS +: BCD_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bin_r <= load_value[VALUE_BITS-1:0];
      bcd_r <= '0;
    end else if (ctl.dabble) begin
      bin_r <= {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_r <= {adjusted[BCD_W-2:0], bin_r[VALUE_BITS-1]};
    end else if (ctl.dshift) begin
      bcd_r <= {bcd_r[BCD_W-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: BCD_BITS];

endmodule
`default_nettype wire

[rtl/core/bdd_ctrl.sv]
// Sequencer for conversion and digit emission, with the registered result stage.
`default_nettype none
module bdd_ctrl
  import bdd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS,
  parameter int unsigned NUM_DIGITS = max_digits(DEFAULT_VALUE_BITS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BCD_BITS-1:0]  top_digit,
  output bdd_ctl_t                  ctl,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CHAR_BITS-1:0]      out_digit_char,
  output logic                      out_last_digit
);

  localparam int unsigned CW = $clog2(VALUE_BITS);

  bdd_state_t           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 seen_r, seen_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0] out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 can_load;
  logic                 is_last;
  logic                 show;

  assign can_load = !out_valid_r || out_ready;
  assign is_last  = (cnt_r == CW'(NUM_DIGITS - 1));
  assign show     = seen_r || (top_digit != '0) || is_last;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(VALUE_BITS - 1)) begin
          cnt_nxt   = '0;
          seen_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          ctl.dshift = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          if (show) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = ASCII_ZERO + {{(CHAR_BITS-BCD_BITS){1'b0}}, top_digit};
            out_last_nxt  = is_last;
            seen_nxt      = 1'b1;
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule
`default_nettype wire

[rtl/core/binary_to_decimal_digits_top.sv]
// Top level of the binary to decimal ASCII digit converter.
// Conversion: VALUE_BITS shift-and-add-3 steps in the shared BCD unit, then one step per
// digit position (NUM_DIGITS, 20 at 64 bits), leading zeros included but not emitted.
// Digit steps wait while the output holds an unaccepted digit. A new value is accepted
// only in idle, after the last digit position; the single BCD register allows no overlap.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
`default_nettype none
module binary_to_decimal_digits_top
  import bdd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [INPUT_BITS-1:0] in_binary_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CHAR_BITS-1:0]       out_digit_char,
  output logic                       out_last_digit
);

  localparam int unsigned NUM_DIGITS = max_digits(VALUE_BITS);

  bdd_ctl_t            ctl;
  logic [BCD_BITS-1:0] top_digit;

  bdd_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk        (clk),
    .ctl        (ctl),
    .load_value (in_binary_value),
    .top_digit  (top_digit)
  );

  bdd_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .top_digit      (top_digit),
    .ctl            (ctl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the binary to decimal ASCII digit converter.
`default_nettype none
module tb
  import bdd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS = DEFAULT_VALUE_BITS;
  localparam int unsigned DIGITS_MAX = 20;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned CALM_ITEMS = 50;
  localparam longint unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } digit_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [INPUT_BITS-1:0] in_binary_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_BITS-1:0]  out_digit_char;
  logic                  out_last_digit;

  logic [INPUT_BITS-1:0] pending_values[$];
  digit_t                expected_digits[$];
  int                    errors = 0;
  bit                    calm = 1'b0;
  int                    send_gap = 0;
  int                    recv_stall = 0;
  longint unsigned       cycle_count = 0;

  binary_to_decimal_digits_top #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_binary_value(in_binary_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  always #1 clk = ~clk;

  // Splits a value into decimal digits, most significant first, and queues them.
  function automatic void predict_digits(input logic [INPUT_BITS-1:0] value);
    logic [63:0] mask;
    logic [63:0] rest;
    logic [3:0]  rev[DIGITS_MAX];
    int          count;
    digit_t      d;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    rest = value & mask;
    count = 0;
    do begin
      rev[count] = 4'(rest % 64'd10);
      count++;
      rest = rest / 64'd10;
    end while (rest != 0 && count < DIGITS_MAX);
    for (int k = 0; k < count; k++) begin
      d.digit_char = ASCII_ZERO + CHAR_BITS'(rev[count - 1 - k]);
      d.last_digit = (k == count - 1);
      expected_digits.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_binary_value <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_digits(in_binary_value);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_values.size() > 0) begin
          in_valid <= 1'b1;
          in_binary_value <= pending_values.pop_front();
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(1, 16);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    digit_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected digit transfer, actual digit_char %0d last_digit %0d",
                   $time, out_digit_char, out_last_digit);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_char !== want.digit_char) begin
            $display("%0t: digit_char expected %0d actual %0d",
                     $time, want.digit_char, out_digit_char);
            errors++;
          end
          if (out_last_digit !== want.last_digit) begin
            $display("%0t: last_digit expected %0d actual %0d",
                     $time, want.last_digit, out_last_digit);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        recv_stall <= $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("binary_to_decimal_digits_top verification failed");
    $finish;
  end

  initial begin
    logic [63:0] value;
    logic [63:0] power;
    int          mode;
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd11);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'd12345);
    pending_values.push_back(64'h0000_0000_FFFF_FFFF);
    pending_values.push_back(64'h0000_0001_0000_0000);
    pending_values.push_back(64'd1000000000000000000);
    pending_values.push_back(64'd9999999999999999999);
    pending_values.push_back(64'd10000000000000000000);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'h8000_0000_0000_0001);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFE);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'd1234567890123456789);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The random values are held back here until every digit of the directed values has arrived.
    while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0) begin
      @(negedge clk);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = $urandom_range(0, 9);
      value = {$urandom, $urandom};
      if (mode <= 4) begin
        value = value >> $urandom_range(0, 63);
      end else if (mode == 5 || mode == 6) begin
        power = 64'd1;
        repeat ($urandom_range(0, 19)) power = power * 64'd10;
        value = power + 64'($urandom_range(0, 2)) - 64'd1;
      end else if (mode == 7) begin
        value = 64'($urandom_range(0, 99));
      end else if (mode == 8) begin
        value = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
      end
      if (i == RANDOM_ITEMS / 2) begin
        while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0) begin
          @(negedge clk);
        end
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        while (pending_values.size() != 0) begin
          @(negedge clk);
        end
        calm = 1'b1;
      end
      pending_values.push_back(value);
    end

    while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0) begin
      @(negedge clk);
    end
    repeat (120) @(negedge clk);

    if (errors == 0) begin
      $display("binary_to_decimal_digits_top verification clean");
    end else begin
      $display("binary_to_decimal_digits_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[binary_to_decimal_digits_top.f]
rtl/core/bdd_pkg.sv
rtl/core/bdd_dabble.sv
rtl/core/bdd_ctrl.sv
rtl/core/binary_to_decimal_digits_top.sv
tb/tb.sv
